@@ hdl/mblm_pkg.sv @@
// ----------------------------------------------------------------------------
// mblm_pkg
// Shared types and constants for the median battery level monitor.
// ----------------------------------------------------------------------------
package mblm_pkg;

    localparam int WINDOW      = 15;
    localparam int SAMPLE_BITS = 12;
    localparam int MID         = WINDOW / 2;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int GAIN_W      = 24;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W;
    localparam int FRAC_W      = 16;
    localparam int MV_W        = 16;
    localparam int PCT_W       = 7;
    localparam int DIFF_W      = 10;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [GAIN_W-1:0]      t_gain;
    typedef logic [MV_W-1:0]        t_mv;
    typedef logic [PCT_W-1:0]       t_pct;

    localparam t_gain GAIN_RESET = 24'd105626;
    localparam t_mv   MV_MAX     = 16'hFFFF;
    localparam t_mv   MV_FULL    = 16'd4200;
    localparam t_mv   MV_EMPTY   = 16'd3000;
    localparam t_mv   MV_KNEE    = 16'd3700;
    localparam t_pct  PCT_KNEE   = 7'd50;
    localparam t_pct  PCT_FULL   = 7'd100;
    localparam t_pct  PCT_ZERO   = 7'd0;

    // reciprocals: x/10 ~ x*205>>11, x/14 ~ x*2341>>15, exact for x < 1024
    localparam logic [7:0]  RCP10   = 8'd205;
    localparam int          RCP10_S = 11;
    localparam logic [11:0] RCP14   = 12'd2341;
    localparam int          RCP14_S = 15;

    localparam logic [ADDR_W-1:0] REG_SCALE_GAIN = 3'd0;

    typedef struct packed {
        logic valid;
        logic space;
    } t_q_stat;

endpackage

@@ hdl/mblm_in_if.sv @@
// ----------------------------------------------------------------------------
// mblm_in_if
// Sample channel: valid/ready handshake with one raw ADC word.
// ----------------------------------------------------------------------------
interface mblm_in_if;
    import mblm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/mblm_out_if.sv @@
// ----------------------------------------------------------------------------
// mblm_out_if
// Result channel: valid/ready handshake with median, millivolts and percent.
// ----------------------------------------------------------------------------
interface mblm_out_if;
    import mblm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample median_count;
    t_mv     voltage_mv;
    t_pct    charge_percent;

    modport source (output valid, output median_count, output voltage_mv,
                    output charge_percent, input ready);
    modport sink   (input valid, input median_count, input voltage_mv,
                    input charge_percent, output ready);
endinterface

@@ hdl/mblm_front.sv @@
// ----------------------------------------------------------------------------
// mblm_front
// Sorted insertion cell row; pushes the window median into the queue.
// ----------------------------------------------------------------------------
module mblm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mblm_in_if.sink           i_in,
    input  mblm_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output mblm_pkg::t_sample o_median
);
    import mblm_pkg::*;

    t_sample          r_cell [WINDOW];
    t_sample          n_cell [WINDOW];
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [WINDOW-1:0] s_le;
    logic             s_last;
    logic             s_acc;

    assign s_last     = (r_fill == CNT_W'(WINDOW - 1));
    assign i_in.ready = !s_last || i_q_stat.space;
    assign s_acc      = i_in.valid && i_in.ready;
    assign o_push     = s_acc && s_last;
    assign o_median   = n_cell[MID];

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            s_le[i] = (CNT_W'(i) < r_fill) && (r_cell[i] <= i_in.sample);
        end
        for (int i = 0; i < WINDOW; i++) begin
            if (s_le[i]) begin
                n_cell[i] = r_cell[i];
            end else if (i == 0) begin
                n_cell[i] = i_in.sample;
            end else if (s_le[(i == 0) ? 0 : i - 1]) begin
                n_cell[i] = i_in.sample;
            end else begin
                n_cell[i] = r_cell[(i == 0) ? 0 : i - 1];
            end
        end
        n_fill = s_last ? '0 : r_fill + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (s_acc) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_cell[i] <= n_cell[i];
            end
        end
    end
endmodule

@@ hdl/mblm_fifo.sv @@
// ----------------------------------------------------------------------------
// mblm_fifo
// Two-word median queue between the cell row and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module mblm_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mblm_pkg::t_sample i_data,
    input  logic              i_pop,
    output mblm_pkg::t_sample o_data,
    output mblm_pkg::t_q_stat o_stat
);
    import mblm_pkg::*;

    t_sample    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.space = (r_cnt != 2'd2);
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

@@ hdl/mblm_back.sv @@
// ----------------------------------------------------------------------------
// mblm_back
// Gain multiply, millivolt saturation and charge percentage pipeline.
// ----------------------------------------------------------------------------
module mblm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mblm_pkg::t_gain   i_gain,
    input  mblm_pkg::t_q_stat i_q_stat,
    input  mblm_pkg::t_sample i_median,
    output logic              o_pop,
    mblm_out_if.source        o_out
);
    import mblm_pkg::*;

    logic                       s_en;
    logic                       r1_v;
    t_sample                    r1_med;
    logic [PROD_W-1:0]          r1_prod;
    logic                       r2_v;
    t_sample                    r2_med;
    t_mv                        r2_mv;
    logic [PROD_W-FRAC_W-1:0]   s_mv_full;
    t_mv                        s_mv;
    logic [DIFF_W-1:0]          s_dhi;
    logic [DIFF_W-1:0]          s_dlo;
    logic [DIFF_W+7:0]          s_phi;
    logic [DIFF_W+11:0]         s_plo;
    t_pct                       s_pct;
    logic                       r_o_v;
    t_sample                    r_o_med;
    t_mv                        r_o_mv;
    t_pct                       r_o_pct;

    assign s_en  = !r_o_v || o_out.ready;
    assign o_pop = s_en && i_q_stat.valid;

    assign s_mv_full = r1_prod[PROD_W-1:FRAC_W];
    assign s_mv      = (s_mv_full > {{(PROD_W-FRAC_W-MV_W){1'b0}}, MV_MAX}) ?
                       MV_MAX : s_mv_full[MV_W-1:0];

    always_comb begin
        s_dhi = DIFF_W'(r2_mv - MV_KNEE);
        s_dlo = DIFF_W'(r2_mv - MV_EMPTY);
        s_phi = s_dhi * RCP10;
        s_plo = s_dlo * RCP14;
        if (r2_mv >= MV_FULL) begin
            s_pct = PCT_FULL;
        end else if (r2_mv <= MV_EMPTY) begin
            s_pct = PCT_ZERO;
        end else if (r2_mv > MV_KNEE) begin
            s_pct = PCT_KNEE + PCT_W'(s_phi >> RCP10_S);
        end else begin
            s_pct = PCT_W'(s_plo >> RCP14_S);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else if (s_en) begin
            r1_v  <= i_q_stat.valid;
            r2_v  <= r1_v;
            r_o_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r1_med  <= i_median;
            r1_prod <= PROD_W'(i_median) * PROD_W'(i_gain);
            r2_med  <= r1_med;
            r2_mv   <= s_mv;
            r_o_med <= r2_med;
            r_o_mv  <= r2_mv;
            r_o_pct <= s_pct;
        end
    end

    assign o_out.valid          = r_o_v;
    assign o_out.median_count   = r_o_med;
    assign o_out.voltage_mv     = r_o_mv;
    assign o_out.charge_percent = r_o_pct;
endmodule

@@ hdl/median_battery_level_monitor_core.sv @@
// ----------------------------------------------------------------------------
// median_battery_level_monitor_core
// A 15-sample window's last word queues its median; it then passes r1, r2, r_o.
// Throughput: one sample per cycle; the cell row inserts each sample as it lands.
// The two-word median queue only stalls the input when it is full at window end.
// Reset (sync, active low) empties the window, queue and pipeline; gain -> 105626.
// ----------------------------------------------------------------------------
module median_battery_level_monitor_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mblm_in_if.sink                     i_in,
    mblm_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mblm_pkg::ADDR_W-1:0] paddr,
    input  logic [mblm_pkg::DATA_W-1:0] pwdata,
    output logic [mblm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import mblm_pkg::*;

    t_gain   r_gain;
    logic    s_hit;
    logic    s_push;
    logic    s_pop;
    t_sample s_fmed;
    t_sample s_qmed;
    t_q_stat s_q_stat;

    assign pready = 1'b1;
    assign s_hit  = (paddr[ADDR_W-1:2] == REG_SCALE_GAIN[ADDR_W-1:2]);
    assign prdata = s_hit ? DATA_W'(r_gain) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && pready && s_hit) begin
            r_gain <= pwdata[GAIN_W-1:0];
        end
    end

    mblm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (s_q_stat),
        .o_push   (s_push),
        .o_median (s_fmed)
    );

    mblm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_fmed),
        .i_pop   (s_pop),
        .o_data  (s_qmed),
        .o_stat  (s_q_stat)
    );

    mblm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain   (r_gain),
        .i_q_stat (s_q_stat),
        .i_median (s_qmed),
        .o_pop    (s_pop),
        .o_out    (o_out)
    );

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> s_q_stat.space) else $error("median pushed into full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> s_q_stat.valid) else $error("median popped from empty queue");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.charge_percent <= PCT_FULL))
        else $error("charge percentage out of range");
endmodule
